// ----- rtl/adpe_pkg.sv -----
// Package: shared constants, bus types and fixed-point helpers for the density evaluator.
`timescale 1ns / 1ps
package adpe_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE_I     = 1 << FRAC_BITS;
	localparam int COS_SH    = 30 - FRAC_BITS;
	localparam int VAL_W     = 24;

	localparam logic [30:0] Q30    = 31'h4000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// Horner divisors for the cosine series
	localparam int unsigned HORNER_N = 6;
	localparam int unsigned HORNER_DIV [HORNER_N] = '{132, 90, 56, 30, 12, 2};

	// square root: FRAC_BITS+1 result bits, three per stage
	localparam int SQ_ITER = FRAC_BITS + 1;
	localparam int SQ_PER  = 3;
	localparam int SQ_STG  = (SQ_ITER + SQ_PER - 1) / SQ_PER;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t DENS_MAX = val_t'(131071);
	localparam val_t DENS_MIN = -val_t'(131072);

	typedef enum logic [2:0] {
		REG_FL  = 3'd0,
		REG_S5  = 3'd1,
		REG_AT2 = 3'd2,
		REG_AS  = 3'd3,
		REG_A5S = 3'd4,
		REG_FS  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [14:0]        fl;
		logic signed [15:0] s5;
		logic [14:0]        at2;
		logic signed [15:0] as_c;
		logic signed [15:0] a5s;
		logic [14:0]        fs;
	} cfg_t;

	// one Horner step bus
	typedef struct packed {
		logic        vld;
		logic        neg;
		logic [31:0] u;
		logic [30:0] r;
	} hb_t;

	// delay line entry
	typedef struct packed {
		logic signed [15:0] cl;
		logic signed [15:0] ck;
	} dl_t;

	// aligned operands for the density arithmetic
	typedef struct packed {
		logic               vld;
		logic signed [15:0] cl;
		logic signed [15:0] ck;
		logic [14:0]        sl;
		logic [14:0]        sk;
		logic signed [15:0] cphi;
	} dens_in_t;

	// (a*b)/ONE, round half up
	function automatic val_t mulq(val_t a, val_t b);
		logic signed [2*VAL_W-1:0] p;
		p = a * b;
		p = p + ((2*VAL_W)'(1) <<< (FRAC_BITS - 1));
		return p[FRAC_BITS +: VAL_W];
	endfunction

endpackage

// ----- rtl/angular_decay_pdf_eval.sv -----
// Top level of the angular decay density evaluator.
`timescale 1ns / 1ps
// Angular decay density evaluator.
// Requests: raise start with cos_lepton, cos_kaon (Q2.14) and azimuth
// (units of pi/32768); the request is taken on any edge with start high,
// busy is held low so a new request may enter every cycle.
// Results: density (signed Q4.14, saturated) and saturated appear with done
// for exactly one cycle, in request order.
// Throughput is one event per cycle; latency is set by the cosine path:
// one input register, four stages of fold and angle scaling, six Horner
// steps of three stages each (multiply, reciprocal multiply, correction),
// one rounding stage, then six stages of density arithmetic.
// The sine roots run alongside in six stages, fed from a delay line.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one coefficient per edge;
// write only while no request is in flight. Unknown indexes are ignored.
// Reset: all coefficients and valid bits clear; pipeline data is not reset.
// The receiver cannot stall, so no output buffering is needed.
module angular_decay_pdf_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] cos_lepton,
	input  logic signed [15:0] cos_kaon,
	input  logic [15:0]        azimuth,
	output logic               done,
	output logic signed [17:0] density,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);
	import adpe_pkg::*;

	localparam int COS_LAT = 1 + 4 + 3 * HORNER_N + 1 - 1;  // cosine unit stages
	localparam int SQ_LAT  = 1 + SQ_STG;
	localparam int DL_LEN  = COS_LAT - SQ_LAT;

	localparam logic signed [15:0] P_ONE = 16'(ONE_I);
	localparam logic signed [15:0] N_ONE = -16'(ONE_I);

	cfg_t cfg_q;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FL:  cfg_q.fl   <= cfg_wdata[14:0];
				REG_S5:  cfg_q.s5   <= cfg_wdata;
				REG_AT2: cfg_q.at2  <= cfg_wdata[14:0];
				REG_AS:  cfg_q.as_c <= cfg_wdata;
				REG_A5S: cfg_q.a5s  <= cfg_wdata;
				REG_FS:  cfg_q.fs   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// input stage: clamp both cosines
	logic               vld_s1;
	logic signed [15:0] cl_s1, ck_s1;
	logic [15:0]        az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cl_s1 <= (cos_lepton > P_ONE) ? P_ONE : (cos_lepton < N_ONE) ? N_ONE : cos_lepton;
		ck_s1 <= (cos_kaon > P_ONE) ? P_ONE : (cos_kaon < N_ONE) ? N_ONE : cos_kaon;
		az_s1 <= azimuth;
	end

	// cosine of azimuth
	logic               cos_vld;
	logic signed [15:0] cphi;

	adpe_cos u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.az      (az_s1),
		.out_vld (cos_vld),
		.cphi    (cphi)
	);

	// delay line so the roots finish with the cosine
	logic dl_vld_q [DL_LEN];
	dl_t  dl_q     [DL_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL_LEN; i++) dl_vld_q[i] <= 1'b0;
		end else begin
			dl_vld_q[0] <= vld_s1;
			for (int i = 1; i < DL_LEN; i++) dl_vld_q[i] <= dl_vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		dl_q[0].cl <= cl_s1;
		dl_q[0].ck <= ck_s1;
		for (int i = 1; i < DL_LEN; i++) begin
			dl_q[i] <= dl_q[i-1];
		end
	end

	logic               sql_vld, sqk_vld;
	logic signed [15:0] sql_c, sqk_c;
	logic [14:0]        sl, sk;

	adpe_sqrt u_sqrt_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dl_vld_q[DL_LEN-1]),
		.in_c    (dl_q[DL_LEN-1].cl),
		.out_vld (sql_vld),
		.out_c   (sql_c),
		.out_s   (sl)
	);

	adpe_sqrt u_sqrt_k (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dl_vld_q[DL_LEN-1]),
		.in_c    (dl_q[DL_LEN-1].ck),
		.out_vld (sqk_vld),
		.out_c   (sqk_c),
		.out_s   (sk)
	);

	dens_in_t dn;

	assign dn.vld  = sql_vld;
	assign dn.cl   = sql_c;
	assign dn.ck   = sqk_c;
	assign dn.sl   = sl;
	assign dn.sk   = sk;
	assign dn.cphi = cphi;

	adpe_dens u_dens (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.din       (dn),
		.out_vld   (done),
		.density   (density),
		.saturated (saturated)
	);

	// cosine path and root path stay aligned
	a_align_cos: assert property (@(posedge clk) disable iff (!arst_n)
		cos_vld == sql_vld) else $error("cosine and root paths out of step");

	a_align_sq: assert property (@(posedge clk) disable iff (!arst_n)
		sqk_vld == sql_vld) else $error("root paths out of step");

	a_sine_rng: assert property (@(posedge clk) disable iff (!arst_n)
		sql_vld |-> (sl <= 15'(ONE_I) && sk <= 15'(ONE_I)))
		else $error("sine above one");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		saturated |-> (done && (density == DENS_MAX[17:0] || density == DENS_MIN[17:0])))
		else $error("saturation flag without clipped value");

endmodule

// ----- rtl/adpe_horner.sv -----
// One Horner step of the cosine series: r' = 1 - round(u*r)/K, three stages.
`timescale 1ns / 1ps
module adpe_horner #(
	parameter int unsigned K = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  adpe_pkg::hb_t din,
	output adpe_pkg::hb_t dout
);
	import adpe_pkg::*;

	localparam longint unsigned RECIP = (64'd1 << 32) / K;
	localparam logic [31:0] RECIP_W = RECIP[31:0];

	logic        vld_s1, vld_s2, vld_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [31:0] u_s1, u_s2, u_s3;
	logic [62:0] prod_s1;
	logic [31:0] p_s2;
	logic [63:0] pm_s2;
	logic [30:0] r_s3;

	logic [62:0]        prod_r;
	logic [31:0]        p_b;
	logic [31:0]        q_est;
	logic [39:0]        rem;
	logic [31:0]        q;
	logic signed [33:0] r_s;

	always_comb begin
		prod_r = prod_s1 + (63'(1) << 29);
		p_b    = prod_r[61:30];
	end

	// reciprocal estimate is exact or one short
	always_comb begin
		q_est = pm_s2[63:32];
		rem   = 40'(p_s2) - 40'(q_est) * 40'(K);
		q     = (rem >= 40'(K)) ? q_est + 32'd1 : q_est;
		r_s   = signed'(34'(Q30)) - signed'(34'(q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= din.neg;
		u_s1    <= din.u;
		prod_s1 <= 63'(din.u) * 63'(din.r);
		neg_s2  <= neg_s1;
		u_s2    <= u_s1;
		p_s2    <= p_b;
		pm_s2   <= 64'(p_b) * 64'(RECIP_W);
		neg_s3  <= neg_s2;
		u_s3    <= u_s2;
		r_s3    <= (r_s < 0) ? 31'd0 : r_s[30:0];
	end

	assign dout = {vld_s3, neg_s3, u_s3, r_s3};

endmodule

// ----- rtl/adpe_cos.sv -----
// Cosine of the azimuth: quadrant fold, angle scaling, six-step Horner series.
`timescale 1ns / 1ps
module adpe_cos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [15:0]        az,
	output logic               out_vld,
	output logic signed [15:0] cphi
);
	import adpe_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_q;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [14:0] x_s1;
	logic [46:0] tprod_s2;
	logic [63:0] uprod_s3;
	logic [31:0] u_s4;
	logic signed [15:0] cphi_q;

	logic [16:0] a_f;
	logic [16:0] a_m;
	logic        neg_f;
	logic [16:0] x_f;
	logic [46:0] t_r;
	logic [31:0] t_v;
	logic [63:0] u_r;
	logic [30:0] rr;
	logic [14:0] c_mag;

	hb_t bus [HORNER_N+1];

	// fold into the first quadrant, note the sign
	always_comb begin
		a_f   = 17'(az);
		a_m   = (a_f > 17'd32768) ? 17'd65536 - a_f : a_f;
		neg_f = a_m > 17'd16384;
		x_f   = neg_f ? 17'd32768 - a_m : a_m;
		t_r   = tprod_s2 + (47'(1) << 14);
		t_v   = t_r[46:15];
		u_r   = uprod_s3 + (64'(1) << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_q  <= bus[HORNER_N].vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= x_f[14:0];
		neg_s1   <= neg_f;
		tprod_s2 <= 47'(x_s1) * 47'(PI_Q30);
		neg_s2   <= neg_s1;
		uprod_s3 <= 64'(t_v) * 64'(t_v);
		neg_s3   <= neg_s2;
		u_s4     <= u_r[61:30];
		neg_s4   <= neg_s3;
		cphi_q   <= bus[HORNER_N].neg ? -signed'({1'b0, c_mag}) : signed'({1'b0, c_mag});
	end

	assign bus[0].vld = vld_s4;
	assign bus[0].neg = neg_s4;
	assign bus[0].u   = u_s4;
	assign bus[0].r   = Q30;

	for (genvar i = 0; i < HORNER_N; i++) begin : g_step
		adpe_horner #(.K(HORNER_DIV[i])) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (bus[i]),
			.dout   (bus[i+1])
		);
	end

	always_comb begin
		rr    = bus[HORNER_N].r + (31'(1) << (COS_SH - 1));
		c_mag = 15'(rr >> COS_SH);
	end

	assign out_vld = vld_q;
	assign cphi    = cphi_q;

endmodule

// ----- rtl/adpe_sqrt.sv -----
// Sine from cosine: floor(sqrt(ONE^2 - c^2)), bit-serial root over pipeline stages.
`timescale 1ns / 1ps
module adpe_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [15:0] in_c,
	output logic               out_vld,
	output logic signed [15:0] out_c,
	output logic [14:0]        out_s
);
	import adpe_pkg::*;

	logic               vld_q [SQ_STG+1];
	logic signed [15:0] c_q   [SQ_STG+1];
	logic [30:0]        n_q   [SQ_STG+1];
	logic [30:0]        res_q [SQ_STG+1];

	logic [31:0] csq;

	assign csq = 32'(in_c) * 32'(in_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		c_q[0]   <= in_c;
		n_q[0]   <= 31'((32'(1) << (2*FRAC_BITS)) - csq);
		res_q[0] <= '0;
	end

	for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
		logic [30:0] n_v;
		logic [30:0] res_v;
		logic [30:0] bit_v;
		always_comb begin
			n_v   = n_q[g];
			res_v = res_q[g];
			bit_v = '0;
			for (int j = 0; j < SQ_PER; j++) begin
				if (g*SQ_PER + j < SQ_ITER) begin
					bit_v = 31'(1) << (2*(FRAC_BITS - (g*SQ_PER + j)));
					if (n_v >= res_v + bit_v) begin
						n_v   = n_v - (res_v + bit_v);
						res_v = (res_v >> 1) + bit_v;
					end else begin
						res_v = res_v >> 1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else begin
				vld_q[g+1] <= vld_q[g];
			end
		end

		always_ff @(posedge clk) begin
			c_q[g+1]   <= c_q[g];
			n_q[g+1]   <= n_v;
			res_q[g+1] <= res_v;
		end
	end

	assign out_vld = vld_q[SQ_STG];
	assign out_c   = c_q[SQ_STG];
	assign out_s   = res_q[SQ_STG][14:0];

endmodule

// ----- rtl/adpe_dens.sv -----
// Density arithmetic: P-wave sum, S-wave scaling and terms, saturation; six stages.
`timescale 1ns / 1ps
module adpe_dens (
	input  logic                      clk,
	input  logic                      arst_n,
	input  adpe_pkg::cfg_t            cfg,
	input  adpe_pkg::dens_in_t        din,
	output logic                      out_vld,
	output logic signed [17:0]        density,
	output logic                      saturated
);
	import adpe_pkg::*;

	localparam val_t ONE_V = val_t'(ONE_I);
	localparam val_t TQ    = val_t'(3 * (ONE_I >> 2));
	localparam val_t QT    = val_t'(ONE_I >> 2);
	localparam val_t HF    = val_t'(ONE_I >> 1);

	val_t fl, s5, at2, as_c, a5s, fs, om_fl, om_fs;
	val_t cl, ck, sl, sk, cphi;

	assign fl    = val_t'({1'b0, cfg.fl});
	assign at2   = val_t'({1'b0, cfg.at2});
	assign fs    = val_t'({1'b0, cfg.fs});
	assign s5    = val_t'(cfg.s5);
	assign as_c  = val_t'(cfg.as_c);
	assign a5s   = val_t'(cfg.a5s);
	assign om_fl = ONE_V - fl;
	assign om_fs = ONE_V - fs;

	assign cl   = val_t'(din.cl);
	assign ck   = val_t'(din.ck);
	assign sl   = val_t'({1'b0, din.sl});
	assign sk   = val_t'({1'b0, din.sk});
	assign cphi = val_t'(din.cphi);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_q;
	val_t c2p_s1, cl2_s1, ck2_s1, skck_s1, sksl_s1, slcp_s1, flat_s1, ck_s1, cphi_s1;
	val_t trans_s2, lng_s2, a1_s2, a2_s2, b1_s2, slcp_s2, c1_s2, d0_s2, e0_s2, cos2l_s2;
	val_t t1_s3, t2_s3, t3_s3, lng_s3, a3_s3, b2_s3, c1_s3, d1_s3, e1_s3;
	val_t part_s4, t2q_s4, a4_s4, sw_s4;
	val_t vs_s5, sw_s5;
	logic signed [17:0] density_q;
	logic               sat_q;

	val_t c2phi, sl2, sk2, sin2k, cos2l, vsum, v6;

	always_comb begin
		c2phi = val_t'(2 * c2p_s1 - ONE_V);
		sl2   = ONE_V - cl2_s1;
		sk2   = ONE_V - ck2_s1;
		sin2k = val_t'(2 * skck_s1);
		cos2l = val_t'(2 * cl2_s1 - ONE_V);
		vsum  = part_s4 + t2q_s4 + a4_s4;
		v6    = vs_s5 + sw_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// squares and cross products
		c2p_s1  <= mulq(cphi, cphi);
		cl2_s1  <= mulq(cl, cl);
		ck2_s1  <= mulq(ck, ck);
		skck_s1 <= mulq(sk, ck);
		sksl_s1 <= mulq(sk, sl);
		slcp_s1 <= mulq(sl, cphi);
		flat_s1 <= mulq(om_fl, at2);
		ck_s1   <= ck;
		cphi_s1 <= cphi;
		// second level
		trans_s2 <= mulq(om_fl, sk2);
		lng_s2   <= mulq(fl, ck2_s1);
		a1_s2    <= mulq(flat_s1, sk2);
		a2_s2    <= mulq(sl2, c2phi);
		b1_s2    <= mulq(s5, sin2k);
		slcp_s2  <= slcp_s1;
		c1_s2    <= mulq(fs, sl2);
		d0_s2    <= mulq(sl2, ck_s1);
		e0_s2    <= mulq(sksl_s1, cphi_s1);
		cos2l_s2 <= cos2l;
		// third level
		t1_s3  <= mulq(TQ, trans_s2);
		t2_s3  <= mulq(trans_s2, cos2l_s2);
		t3_s3  <= mulq(lng_s2, cos2l_s2);
		lng_s3 <= lng_s2;
		a3_s3  <= mulq(a1_s2, a2_s2);
		b2_s3  <= mulq(b1_s2, slcp_s2);
		c1_s3  <= c1_s2;
		d1_s3  <= mulq(as_c, d0_s2);
		e1_s3  <= mulq(a5s, e0_s2);
		// fourth level
		part_s4 <= t1_s3 + lng_s3 - t3_s3 + b2_s3;
		t2q_s4  <= mulq(QT, t2_s3);
		a4_s4   <= mulq(HF, a3_s3);
		sw_s4   <= c1_s3 + d1_s3 + e1_s3;
		// P-wave scaled by (1 - Fs)
		vs_s5 <= mulq(vsum, om_fs);
		sw_s5 <= sw_s4;
		// saturate
		if (v6 > DENS_MAX) begin
			density_q <= DENS_MAX[17:0];
			sat_q     <= 1'b1;
		end else if (v6 < DENS_MIN) begin
			density_q <= DENS_MIN[17:0];
			sat_q     <= 1'b1;
		end else begin
			density_q <= v6[17:0];
			sat_q     <= 1'b0;
		end
	end

	assign out_vld   = vld_q;
	assign density   = density_q;
	assign saturated = sat_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the angular decay density evaluator.
`timescale 1ns / 1ps
// What is tested: density and saturated for each event, against a bit-true
// predictor held here (clamping of cosines, integer-root sines, series cosine
// of the azimuth, P-wave and S-wave sums, saturation to 18 bits).
// How: directed extremes first, then random events under several coefficient
// settings, including out-of-range raw coefficients. Three idle mixes are
// run on the request side. Results cannot be held off, so the checker simply
// pops the oldest expectation on every done.
module testbench;
	import adpe_pkg::*;

	localparam int FB       = 14;
	localparam longint ONE  = longint'(1) << FB;
	localparam longint Q30L = longint'(1) << 30;
	localparam longint PI30 = 64'sd3373259426;
	localparam int LATENCY  = 30;
	localparam int WD_LIMIT = 5000;

	typedef struct {
		logic signed [17:0] dens;
		logic               sat;
	} density_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] cos_lepton = '0;
	logic signed [15:0] cos_kaon = '0;
	logic [15:0]        azimuth = '0;
	logic               done;
	logic signed [17:0] density;
	logic               saturated;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_idx = '0;
	logic [15:0]        cfg_wdata = '0;

	// coefficient copies as the block holds them
	longint fl_c, s5_c, at2_c, as_c, a5s_c, fs_c;

	density_t expected_q[$];
	int  errors = 0;
	int  n_events = 0;
	int  n_checked = 0;
	int  n_sat = 0;
	int  idle_pct = 0;
	int  quiet_cycles = 0;

	angular_decay_pdf_eval u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cos_lepton(cos_lepton), .cos_kaon(cos_kaon), .azimuth(azimuth),
		.done(done), .density(density), .saturated(saturated),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	// product scaled back by ONE, ties rounded towards +inf (>>> floors)
	function automatic longint qmul(longint a, longint b);
		return (a * b + (longint'(1) << (FB - 1))) >>> FB;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic longint int_root(longint n_in);
		longint unsigned n, res, b;
		n = n_in;
		res = 0;
		b = longint'(1) << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	// cosine on the first quadrant, x in [0,16384] units of pi/32768
	function automatic longint quad_cos(longint x);
		longint t, u, r, p;
		longint divs [6];
		divs = '{132, 90, 56, 30, 12, 2};
		t = (x * PI30 + (longint'(1) << 14)) >> 15;
		u = (t * t + (longint'(1) << 29)) >> 30;
		r = Q30L;
		for (int i = 0; i < 6; i++) begin
			p = (u * r + (longint'(1) << 29)) >> 30;
			r = Q30L - p / divs[i];
			if (r < 0) r = 0;
		end
		return (r + (longint'(1) << (29 - FB))) >>> (30 - FB);
	endfunction

	function automatic longint azimuth_cos(logic [15:0] az);
		longint a;
		a = longint'(az);
		if (a > 32768) a = 65536 - a;
		if (a > 16384) return -quad_cos(32768 - a);
		return quad_cos(a);
	endfunction

	function automatic density_t predict_density(logic signed [15:0] cl_in,
			logic signed [15:0] ck_in, logic [15:0] az);
		longint cl, ck, cphi, c2phi, sl, sk, cl2, ck2, sl2, sk2, sin2k, cos2l;
		longint om_fl, trans, lng, v;
		density_t res;
		cl = clamp_unit(longint'(cl_in));
		ck = clamp_unit(longint'(ck_in));
		cphi = azimuth_cos(az);
		c2phi = 2 * qmul(cphi, cphi) - ONE;
		sl = int_root(ONE * ONE - cl * cl);
		sk = int_root(ONE * ONE - ck * ck);
		cl2 = qmul(cl, cl);
		ck2 = qmul(ck, ck);
		sl2 = ONE - cl2;
		sk2 = ONE - ck2;
		sin2k = 2 * qmul(sk, ck);
		cos2l = 2 * cl2 - ONE;
		om_fl = ONE - fl_c;
		trans = qmul(om_fl, sk2);
		lng = qmul(fl_c, ck2);
		v = qmul(3 * (ONE >> 2), trans);
		v += lng;
		v += qmul(ONE >> 2, qmul(trans, cos2l));
		v -= qmul(lng, cos2l);
		v += qmul(ONE >> 1, qmul(qmul(qmul(om_fl, at2_c), sk2), qmul(sl2, c2phi)));
		v += qmul(qmul(s5_c, sin2k), qmul(sl, cphi));
		v = qmul(v, ONE - fs_c);
		v += qmul(fs_c, sl2);
		v += qmul(as_c, qmul(sl2, ck));
		v += qmul(a5s_c, qmul(qmul(sk, sl), cphi));
		res.sat = 1'b0;
		if (v > 131071) begin
			v = 131071;
			res.sat = 1'b1;
		end
		if (v < -131072) begin
			v = -131072;
			res.sat = 1'b1;
		end
		res.dens = v[17:0];
		return res;
	endfunction

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		density_t e;
		if (done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual density=%0d sat=%0b",
					$time, density, saturated);
				errors++;
			end else begin
				e = expected_q.pop_front();
				n_checked++;
				if (e.sat) n_sat++;
				if (density !== e.dens) begin
					$display("%0t: density mismatch, expected %0d, actual %0d",
						$time, e.dens, density);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated mismatch, expected %0b, actual %0b",
						$time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no request taken, no result and no write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding",
				$time, expected_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------- drivers ----------------

	// one request; start is left high so back-to-back requests need no toggle
	task automatic send_event(logic signed [15:0] cl, logic signed [15:0] ck,
			logic [15:0] az);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cos_lepton <= cl;
		cos_kaon <= ck;
		azimuth <= az;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_density(cl, ck, az));
		n_events++;
		@(negedge clk);
	endtask

	// stop requesting, wait for every result, then let the pipe empty
	task automatic drain;
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_coef(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FL:  fl_c = longint'(val[14:0]);
			REG_S5:  s5_c = longint'($signed(val));
			REG_AT2: at2_c = longint'(val[14:0]);
			REG_AS:  as_c = longint'($signed(val));
			REG_A5S: a5s_c = longint'($signed(val));
			REG_FS:  fs_c = longint'(val[14:0]);
			default: ;
		endcase
	endtask

	task automatic set_coefs(logic [15:0] fl, logic [15:0] s5, logic [15:0] at2,
			logic [15:0] asv, logic [15:0] a5s, logic [15:0] fs);
		drain();
		write_coef(REG_FL, fl);
		write_coef(REG_S5, s5);
		write_coef(REG_AT2, at2);
		write_coef(REG_AS, asv);
		write_coef(REG_A5S, a5s);
		write_coef(REG_FS, fs);
	endtask

	function automatic logic [15:0] rand_signed_unit();
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	// mostly in-range events, some raw 16-bit noise on every field
	task automatic send_random_event;
		logic signed [15:0] cl, ck;
		logic [15:0] az;
		cl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rand_signed_unit();
		ck = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rand_signed_unit();
		az = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
		send_event(cl, ck, az);
	endtask

	// ---------------- tests ----------------

	// all coefficients zero after reset
	task automatic test_reset_coefs;
		send_event(16'sd0, 16'sd0, 16'd0);
		send_event(16'sd16384, -16'sd16384, 16'd16384);
		send_event(-16'sd8192, 16'sd8192, 16'd8192);
	endtask

	// field extremes, clamping beyond one, every azimuth quadrant and wrap
	task automatic test_directed_extremes;
		set_coefs(16'd16384, 16'd16384, 16'd16384, -16'sd16384, 16'd16384, 16'd0);
		send_event(16'sd16384, 16'sd16384, 16'd0);
		send_event(-16'sd16384, -16'sd16384, 16'd32768);
		send_event(16'sd32767, -16'sd32768, 16'd16384);
		send_event(-16'sd32768, 16'sd32767, 16'd16385);
		send_event(16'sd0, 16'sd11585, 16'd24576);
		send_event(16'sd11585, 16'sd0, 16'd32769);
		send_event(-16'sd11585, 16'sd5000, 16'd49152);
		send_event(16'sd1, -16'sd1, 16'd65535);
		send_event(16'sd16385, -16'sd16385, 16'hAAAA);
		send_event(16'sh5555, 16'shAAAA, 16'h5555);
		// raw out-of-range coefficients, pushes the sum into saturation
		set_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_event(16'sd11585, 16'sd11585, 16'd0);
		send_event(-16'sd11585, 16'sd11585, 16'd32768);
		send_event(16'sd0, 16'sd0, 16'd16384);
		set_coefs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
		send_event(16'sd11585, -16'sd11585, 16'd0);
		send_event(16'sd8000, 16'sd8000, 16'd4000);
		send_event(-16'sd16384, 16'sd0, 16'd60000);
		// pure S-wave
		set_coefs(16'd0, 16'd0, 16'd0, 16'd16384, -16'sd16384, 16'd16384);
		send_event(16'sd5000, -16'sd7000, 16'd12000);
		send_event(-16'sd16384, 16'sd16384, 16'd32768);
	endtask

	task automatic test_random_phase(int n, int pct);
		idle_pct = pct;
		case ($urandom_range(0, 3))
			0: set_coefs(16'($urandom_range(0, 16384)), rand_signed_unit(),
				16'($urandom_range(0, 16384)), rand_signed_unit(),
				rand_signed_unit(), 16'($urandom_range(0, 16384)));
			1: set_coefs(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			default: set_coefs(16'($urandom_range(0, 16384)), rand_signed_unit(),
				16'($urandom_range(0, 16384)), rand_signed_unit(),
				rand_signed_unit(), 16'($urandom_range(0, 6000)));
		endcase
		for (int i = 0; i < n; i++) begin
			send_random_event();
			// occasional full pause until everything is back
			if ($urandom_range(0, 199) == 0) drain();
		end
	endtask

	initial begin
		fl_c = 0; s5_c = 0; at2_c = 0; as_c = 0; a5s_c = 0; fs_c = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_coefs();
		test_directed_extremes();
		for (int p = 0; p < 4; p++) test_random_phase(70, 38);
		for (int p = 0; p < 4; p++) test_random_phase(70, 68);
		for (int p = 0; p < 4; p++) test_random_phase(70, 0);
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		$display("Covered %0d events (%0d checked, %0d saturated) over 16 coefficient",
			n_events, n_checked, n_sat);
		$display("settings, with clamped cosines, all azimuth quadrants and three idle mixes.");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
